// ----- hdl/pws_pkg.sv -----
// ----------------------------------------------------------------------------
// pws_pkg
// Shared types, widths and the quarter-wave sine table for the phase
// waveform shaper.
// ----------------------------------------------------------------------------
package pws_pkg;

  localparam int PHASE_BITS      = 16;
  localparam int SAMPLE_BITS     = 16;
  localparam int SINE_TABLE_BITS = 8;

  localparam int TAB_N     = 1 << SINE_TABLE_BITS;
  localparam int QUAD_BITS = PHASE_BITS - 2;
  // interpolation fraction bits below the table index (positive here)
  localparam int FRAC_BITS = QUAD_BITS - SINE_TABLE_BITS;
  localparam int TAB_IDX_W = SINE_TABLE_BITS + 1;

  // working width for sample arithmetic: +2^(S-1) and -2^(S-1) with margin
  localparam int WORK_BITS = SAMPLE_BITS + 2;

  typedef enum logic [1:0] {
    WAVE_SINE   = 2'd0,
    WAVE_SAW    = 2'd1,
    WAVE_SQUARE = 2'd2,
    WAVE_TRI    = 2'd3
  } wave_t;

  typedef logic [SAMPLE_BITS-1:0] sine_tab_t [0:TAB_N];

  // Q30 Taylor series of sin(pi/2 * k/N), rounded half up to S-1 bits.
  // Evaluated at elaboration only.
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t         tab;
    longint unsigned   x;
    longint unsigned   x2;
    longint unsigned   term;
    longint            sum;
    longint unsigned   prod;
    for (int k = 0; k <= TAB_N; k++) begin
      x    = (64'h6487ED51 * longint'(k)) >> SINE_TABLE_BITS;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 7; n++) begin
        prod = (term * x2) >> 30;
        case (n)
          1:       term = prod / 64'd6;
          2:       term = prod / 64'd20;
          3:       term = prod / 64'd42;
          4:       term = prod / 64'd72;
          5:       term = prod / 64'd110;
          6:       term = prod / 64'd156;
          default: term = prod / 64'd210;
        endcase
        if ((n % 2) == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      tab[k] = SAMPLE_BITS'((unsigned'(sum) + (64'd1 << (30 - SAMPLE_BITS)))
                            >> (31 - SAMPLE_BITS));
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

// ----- hdl/phase_waveform_shaper_core.sv -----
// ----------------------------------------------------------------------------
// phase_waveform_shaper_core
// Path: the input word is captured in the input register, then the shaped
// result in the result register. Throughput: one word per cycle unless out_ready
// holds the output; the shaping logic sits between the two registers and both
// stages stall under backpressure.
// Reset: rst (synchronous) clears both stage valids and sets waveform to sine.
// ----------------------------------------------------------------------------
module phase_waveform_shaper_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [1:0]                        cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [pws_pkg::PHASE_BITS-1:0]    phase_in,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [pws_pkg::SAMPLE_BITS-1:0] sample_out
);
  import pws_pkg::*;

  localparam logic signed [WORK_BITS-1:0] HALF   = WORK_BITS'(1) <<< (SAMPLE_BITS - 1);
  localparam logic signed [WORK_BITS-1:0] MAXPOS = HALF - WORK_BITS'(1);
  localparam logic [QUAD_BITS:0]          QSIZE  = (QUAD_BITS+1)'(1) << QUAD_BITS;
  localparam logic [PHASE_BITS-1:0]       MID    = PHASE_BITS'(1) << (PHASE_BITS - 1);
  localparam logic [FRAC_BITS:0]          FONE   = (FRAC_BITS+1)'(1) << FRAC_BITS;

  wave_t                   waveform_select;
  logic                    s1_valid;
  logic [PHASE_BITS-1:0]   s1_phase;
  logic                    s1_ready;
  logic                    s2_ready;

  // ---- sine path ----
  logic [1:0]                quad;
  logic [QUAD_BITS:0]        u;
  logic [TAB_IDX_W-1:0]      idx;
  logic [FRAC_BITS-1:0]      frac;
  logic [TAB_IDX_W-1:0]      idx_a;
  logic [TAB_IDX_W-1:0]      idx_b;
  logic [SAMPLE_BITS-1:0]    tab_a;
  logic [SAMPLE_BITS-1:0]    tab_b;
  logic [SAMPLE_BITS+FRAC_BITS+1:0] interp;
  logic [WORK_BITS-1:0]      sine_mag;
  logic signed [WORK_BITS-1:0] sine_v;

  // ---- other shapes ----
  logic [PHASE_BITS+SAMPLE_BITS-1:0]   saw_wide;
  logic signed [WORK_BITS-1:0]         saw_v;
  logic signed [WORK_BITS-1:0]         sq_v;
  logic [PHASE_BITS-1:0]               tri_d;
  logic [PHASE_BITS+SAMPLE_BITS:0]     tri_wide;
  logic signed [WORK_BITS-1:0]         tri_v;

  logic signed [WORK_BITS-1:0]         shaped;
  logic signed [SAMPLE_BITS-1:0]       sample_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      waveform_select <= WAVE_SINE;
    end else if (cfg_wr_en) begin
      waveform_select <= wave_t'(cfg_wr_data);
    end
  end

  assign s2_ready = !out_valid || out_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_phase <= phase_in;
    end
  end

  // mirror position in odd quadrants; u may reach the quarter point itself
  always_comb begin
    quad = s1_phase[PHASE_BITS-1 -: 2];
    u    = {1'b0, s1_phase[QUAD_BITS-1:0]};
    if (quad[0]) begin
      u = QSIZE - u;
    end
    idx  = u[QUAD_BITS -: TAB_IDX_W];
    frac = u[FRAC_BITS-1:0];
  end

  assign idx_a = {1'b0, idx[SINE_TABLE_BITS-1:0]};
  assign idx_b = idx_a + TAB_IDX_W'(1);
  assign tab_a = SINE_TAB[idx_a];
  assign tab_b = SINE_TAB[idx_b];

  assign interp = ((SAMPLE_BITS+FRAC_BITS+2)'(tab_a) * (SAMPLE_BITS+FRAC_BITS+2)'(FONE - {1'b0, frac})
                 + (SAMPLE_BITS+FRAC_BITS+2)'(tab_b) * (SAMPLE_BITS+FRAC_BITS+2)'(frac))
                 >> FRAC_BITS;

  always_comb begin
    if (idx[SINE_TABLE_BITS]) begin
      sine_mag = WORK_BITS'(SINE_TAB[TAB_N]);
    end else begin
      sine_mag = interp[WORK_BITS-1:0];
    end
    sine_v = quad[1] ? -$signed(sine_mag) : $signed(sine_mag);
  end

  assign saw_wide = {s1_phase, {SAMPLE_BITS{1'b0}}} >> PHASE_BITS;
  assign saw_v    = $signed({1'b0, saw_wide[SAMPLE_BITS:0]}) - HALF;

  assign sq_v = s1_phase[PHASE_BITS-1] ? -HALF : HALF;

  assign tri_d    = (s1_phase >= MID) ? (s1_phase - MID) : (MID - s1_phase);
  assign tri_wide = {tri_d, {(SAMPLE_BITS+1){1'b0}}} >> PHASE_BITS;
  assign tri_v    = HALF - $signed({1'b0, tri_wide[SAMPLE_BITS:0]});

  always_comb begin
    case (waveform_select)
      WAVE_SINE:   shaped = sine_v;
      WAVE_SAW:    shaped = saw_v;
      WAVE_SQUARE: shaped = sq_v;
      default:     shaped = tri_v;
    endcase
  end

  // clip full scale +1 to the largest positive code
  always_comb begin
    if (shaped > MAXPOS) begin
      sample_next = MAXPOS[SAMPLE_BITS-1:0];
    end else if (shaped < -HALF) begin
      sample_next = SAMPLE_BITS'(-HALF);
    end else begin
      sample_next = shaped[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      sample_out <= sample_next;
    end
  end

endmodule
